// ===== rtl/ccd_pkg.sv =====
// Shared types and constants for the composite colour decoder.
// Used by ccd_decode_pipe, ccd_result_fifo and composite_colour_decoder_unit.
`default_nettype none

package ccd_pkg;

  localparam int DEF_FRACTION_BITS = 12;
  localparam int DEF_RESULT_DEPTH  = 16;

  localparam int REG_W      = 20;
  localparam int SAMPLE_W   = 16;
  localparam int CODE_W     = 4;
  localparam int INDEX_W    = 10;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  // YIQ to RGB weights at 16 fraction bits, sign folded in
  localparam int CONV_W = 18;
  localparam logic signed [CONV_W-1:0] CONV_I [3] = '{
    18'sd62672, -18'sd17832, -18'sd72542
  };
  localparam logic signed [CONV_W-1:0] CONV_Q [3] = '{
    18'sd40698, -18'sd42428, 18'sd111713
  };

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_DECODE = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONTRAST   = 2'd0,
    CFG_BRIGHTNESS = 2'd1,
    CFG_CHROMA_RE  = 2'd2,
    CFG_CHROMA_IM  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [REG_W-1:0] contrast;
    logic signed [REG_W-1:0] brightness;
    logic signed [REG_W-1:0] chroma_re;
    logic signed [REG_W-1:0] chroma_im;
  } ccd_cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              clipped;
  } ccd_result_t;

endpackage

`default_nettype wire

// ===== rtl/ccd_decode_pipe.sv =====
// Sample table banks and the fixed-point YIQ to RGB datapath.
// Depends on ccd_pkg. Eight register stages, no stall: one item per cycle.
`default_nettype none

module ccd_decode_pipe #(
  parameter int FRACTION_BITS = ccd_pkg::DEF_FRACTION_BITS
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    load_i,
  input  wire  [ccd_pkg::INDEX_W-1:0]            load_index_i,
  input  wire  [ccd_pkg::SAMPLE_W-1:0]           load_value_i,
  input  wire                                    decode_i,
  input  wire  [ccd_pkg::CODE_W-1:0]             pixel_a_i,
  input  wire  [ccd_pkg::CODE_W-1:0]             pixel_b_i,
  input  wire  [ccd_pkg::CODE_W-1:0]             pixel_c_i,
  input  wire  [ccd_pkg::CODE_W-1:0]             pixel_d_i,
  input  ccd_pkg::ccd_cfg_t                      cfg_i,
  output logic                                   res_valid_o,
  output ccd_pkg::ccd_result_t                   res_o
);
  import ccd_pkg::*;

  localparam int BANK_DEPTH = 1 << (INDEX_W - 1);
  localparam int SUM_W  = SAMPLE_W + 2;
  localparam int DIF_W  = SAMPLE_W + 1;
  localparam int PY_W   = SUM_W + REG_W;
  localparam int BRI_W  = REG_W + FRACTION_BITS + 2;
  localparam int YW_W   = ((PY_W > BRI_W) ? PY_W : BRI_W) + 1;
  localparam int PC_W   = DIF_W + REG_W;
  localparam int IQ_W   = PC_W + 2;
  localparam int LO_W   = 20;
  localparam int HI_W   = IQ_W - LO_W;
  localparam int PLO_W  = CONV_W + LO_W + 1;
  localparam int PHI_W  = CONV_W + HI_W;
  localparam int CI_W   = CONV_W + IQ_W;
  localparam int Y16_W  = YW_W + 16;
  localparam int W_W    = ((Y16_W > CI_W) ? Y16_W : CI_W) + 2;
  localparam int K      = 2 * FRACTION_BITS + 10;
  localparam int STAGES = 8;

  // bank0 holds phases 0 and 1, bank1 phases 2 and 3
  logic [SAMPLE_W-1:0] bank0_mem [BANK_DEPTH];
  logic [SAMPLE_W-1:0] bank1_mem [BANK_DEPTH];

  logic [STAGES-1:0] vld_q;

  logic signed [SAMPLE_W-1:0] s0_q, s1_q, s2_q, s3_q;
  logic signed [SUM_W-1:0]    sum_d, sum_q;
  logic signed [DIF_W-1:0]    di_d, di_q, dq_d, dq_q;
  logic signed [PY_W-1:0]     py_d, py_q;
  logic signed [PC_W-1:0]     p_dr_d, p_dr_q, p_qi_d, p_qi_q;
  logic signed [PC_W-1:0]     p_di_d, p_di_q, p_qr_d, p_qr_q;
  logic signed [YW_W-1:0]     yw_d, yw_q, y5_q, y6_q;
  logic signed [IQ_W-1:0]     iw_d, iw_q, qw_d, qw_q;
  logic signed [PLO_W-1:0]    ilo_d [3], ilo_q [3], qlo_d [3], qlo_q [3];
  logic signed [PHI_W-1:0]    ihi_d [3], ihi_q [3], qhi_d [3], qhi_q [3];
  logic signed [CI_W-1:0]     ci_d [3], ci_q [3], cq_d [3], cq_q [3];
  logic signed [W_W-1:0]      w_d [3], w_q [3];
  logic [CHAN_W-1:0]          chan [3];
  logic [2:0]                 clip;
  ccd_result_t                res_d, res_q;

  always_ff @(posedge clk_i) begin
    if (load_i && !load_index_i[1]) begin
      bank0_mem[{load_index_i[INDEX_W-1:2], load_index_i[0]}] <= load_value_i;
    end
    if (decode_i) begin
      s0_q <= bank0_mem[{pixel_a_i, pixel_b_i, 1'b0}];
      s1_q <= bank0_mem[{pixel_b_i, pixel_c_i, 1'b1}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && load_index_i[1]) begin
      bank1_mem[{load_index_i[INDEX_W-1:2], load_index_i[0]}] <= load_value_i;
    end
    if (decode_i) begin
      s2_q <= bank1_mem[{pixel_c_i, pixel_d_i, 1'b0}];
      s3_q <= bank1_mem[{pixel_d_i, pixel_a_i, 1'b1}];
    end
  end

  always_comb begin
    sum_d  = SUM_W'(s0_q) + SUM_W'(s1_q) + SUM_W'(s2_q) + SUM_W'(s3_q);
    di_d   = DIF_W'(s0_q) - DIF_W'(s2_q);
    dq_d   = DIF_W'(s1_q) - DIF_W'(s3_q);

    py_d   = sum_q * $signed(cfg_i.contrast);
    p_dr_d = di_q * $signed(cfg_i.chroma_re);
    p_qi_d = dq_q * $signed(cfg_i.chroma_im);
    p_di_d = di_q * $signed(cfg_i.chroma_im);
    p_qr_d = dq_q * $signed(cfg_i.chroma_re);

    yw_d   = YW_W'(py_q) + (YW_W'($signed(cfg_i.brightness)) <<< (FRACTION_BITS + 2));
    iw_d   = (IQ_W'(p_dr_q) - IQ_W'(p_qi_q)) <<< 1;
    qw_d   = (IQ_W'(p_di_q) + IQ_W'(p_qr_q)) <<< 1;

    for (int ch = 0; ch < 3; ch++) begin
      ilo_d[ch] = CONV_I[ch] * $signed({1'b0, iw_q[LO_W-1:0]});
      ihi_d[ch] = CONV_I[ch] * $signed(iw_q[IQ_W-1:LO_W]);
      qlo_d[ch] = CONV_Q[ch] * $signed({1'b0, qw_q[LO_W-1:0]});
      qhi_d[ch] = CONV_Q[ch] * $signed(qw_q[IQ_W-1:LO_W]);

      ci_d[ch] = (CI_W'(ihi_q[ch]) <<< LO_W) + CI_W'(ilo_q[ch]);
      cq_d[ch] = (CI_W'(qhi_q[ch]) <<< LO_W) + CI_W'(qlo_q[ch]);

      w_d[ch] = (W_W'(y6_q) <<< 16) + W_W'(ci_q[ch]) + W_W'(cq_q[ch]);

      if (w_q[ch][W_W-1]) begin
        chan[ch] = '0;
        clip[ch] = 1'b1;
      end else if (|w_q[ch][W_W-2:K+CHAN_W]) begin
        chan[ch] = '1;
        clip[ch] = 1'b1;
      end else begin
        chan[ch] = w_q[ch][K+CHAN_W-1:K];
        clip[ch] = 1'b0;
      end
    end

    res_d.red     = chan[0];
    res_d.green   = chan[1];
    res_d.blue    = chan[2];
    res_d.clipped = |clip;
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    di_q   <= di_d;
    dq_q   <= dq_d;
    py_q   <= py_d;
    p_dr_q <= p_dr_d;
    p_qi_q <= p_qi_d;
    p_di_q <= p_di_d;
    p_qr_q <= p_qr_d;
    yw_q   <= yw_d;
    iw_q   <= iw_d;
    qw_q   <= qw_d;
    y5_q   <= yw_q;
    y6_q   <= y5_q;
    for (int ch = 0; ch < 3; ch++) begin
      ilo_q[ch] <= ilo_d[ch];
      ihi_q[ch] <= ihi_d[ch];
      qlo_q[ch] <= qlo_d[ch];
      qhi_q[ch] <= qhi_d[ch];
      ci_q[ch]  <= ci_d[ch];
      cq_q[ch]  <= cq_d[ch];
      w_q[ch]   <= w_d[ch];
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STAGES-2:0], decode_i};
    end
  end

  assign res_valid_o = vld_q[STAGES-1];
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/ccd_result_fifo.sv =====
// Result queue between the decode datapath and the master stream side.
// Depends on ccd_pkg for the result item type.
`default_nettype none

module ccd_result_fifo #(
  parameter int DEPTH = ccd_pkg::DEF_RESULT_DEPTH
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  ccd_pkg::ccd_result_t  data_i,
  input  wire                   pop_i,
  output logic                  valid_o,
  output ccd_pkg::ccd_result_t  data_o
);
  import ccd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ccd_result_t    fifo_mem [DEPTH];
  logic [PW-1:0]  wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CW-1:0]  count_d, count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_mem[wr_ptr_q] <= data_i;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = fifo_mem[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/composite_colour_decoder_unit.sv =====
// Throughput: one item per cycle, load or decode, while s_axis_tready is high.
// A decode result passes the ccd_decode_pipe register stages and then the result queue before its handshake.
// s_axis_tready drops only while RESULT_DEPTH results are owed (result queue depth).
// Reset: config registers take their defaults; table banks hold nothing until loaded,
// and no clearing pass runs. Depends on ccd_pkg, ccd_decode_pipe, ccd_result_fifo.
`default_nettype none

module composite_colour_decoder_unit #(
  parameter int FRACTION_BITS = ccd_pkg::DEF_FRACTION_BITS,
  parameter int RESULT_DEPTH  = ccd_pkg::DEF_RESULT_DEPTH
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // table_index[9:0], sample_value[25:10], pixel_a[29:26], pixel_b[33:30],
  // pixel_c[37:34], pixel_d[41:38], zero[47:42]
  input  wire  [ccd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // action[0]
  input  wire                                 s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [ccd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // clipped[0]
  output logic                                m_axis_tuser,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [ccd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [ccd_pkg::REG_W-1:0]           cfg_data_i
);
  import ccd_pkg::*;

  localparam int OW = $clog2(RESULT_DEPTH + 1);

  ccd_cfg_t        cfg_d, cfg_q;
  logic [OW-1:0]   occ_d, occ_q;
  logic            in_acc, out_acc, load_acc, dec_acc;
  logic            res_valid;
  ccd_result_t     res, head;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign load_acc = in_acc && (action_e'(s_axis_tuser) == ACT_LOAD);
  assign dec_acc  = in_acc && (action_e'(s_axis_tuser) == ACT_DECODE);

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CONTRAST:   cfg_d.contrast   = cfg_data_i;
        CFG_BRIGHTNESS: cfg_d.brightness = cfg_data_i;
        CFG_CHROMA_RE:  cfg_d.chroma_re  = cfg_data_i;
        CFG_CHROMA_IM:  cfg_d.chroma_im  = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.contrast   <= REG_W'(1) << FRACTION_BITS;
      cfg_q.brightness <= '0;
      cfg_q.chroma_re  <= REG_W'(1) << FRACTION_BITS;
      cfg_q.chroma_im  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // count results owed: in flight plus queued
  assign occ_d         = occ_q + OW'(dec_acc) - OW'(out_acc);
  assign s_axis_tready = (occ_q != OW'(RESULT_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  ccd_decode_pipe #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load_acc),
    .load_index_i (s_axis_tdata[9:0]),
    .load_value_i (s_axis_tdata[25:10]),
    .decode_i     (dec_acc),
    .pixel_a_i    (s_axis_tdata[29:26]),
    .pixel_b_i    (s_axis_tdata[33:30]),
    .pixel_c_i    (s_axis_tdata[37:34]),
    .pixel_d_i    (s_axis_tdata[41:38]),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ccd_result_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (out_acc),
    .valid_o (m_axis_tvalid),
    .data_o  (head)
  );

  assign m_axis_tdata = {head.blue, head.green, head.red};
  assign m_axis_tuser = head.clipped;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(RESULT_DEPTH))
    else $error("owed result count above queue depth");

  a_valid_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (occ_q != '0))
    else $error("result offered with none owed");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_acc && !out_acc) |=> (occ_q == $past(occ_q)))
    else $error("load item changed owed result count");

  a_push_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (occ_q != '0))
    else $error("datapath produced a result with none owed");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for composite_colour_decoder_unit: directed table then random loads and decodes.
// An RGB predictor or a directed row checks every result. Depends on ccd_pkg and the unit RTL.
`timescale 1ns / 1ps

module testbench;
  import ccd_pkg::*;

  localparam int FB           = DEF_FRACTION_BITS;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 400;

  localparam longint K_RI = 62672;
  localparam longint K_RQ = 40698;
  localparam longint K_GI = 17832;
  localparam longint K_GQ = 42428;
  localparam longint K_BI = 72542;
  localparam longint K_BQ = 111713;

  typedef struct packed {
    action_e                   act;
    logic [INDEX_W-1:0]        idx;
    logic signed [SAMPLE_W-1:0] smp;
    logic [CODE_W-1:0]         pa;
    logic [CODE_W-1:0]         pb;
    logic [CODE_W-1:0]         pc;
    logic [CODE_W-1:0]         pd;
  } pix_item_t;

  typedef struct {
    pix_item_t   it;
    bit          chk;
    ccd_result_t rgb;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [REG_W-1:0] cfg_data_i;

  logic signed [SAMPLE_W-1:0] wave_tbl [1024];
  bit tbl_loaded [1024];
  logic signed [REG_W-1:0] gain_con;
  logic signed [REG_W-1:0] gain_bri;
  logic signed [REG_W-1:0] gain_re;
  logic signed [REG_W-1:0] gain_im;

  ccd_result_t rgb_expected_q [$];
  dir_row_t dir_rows [$];
  ccd_result_t got_rgb;
  ccd_result_t want_rgb;

  int err_count = 0;
  int n_loads;
  int n_decodes;
  int n_results = 0;
  int n_clipped = 0;
  int n_settings;
  int burst_left;
  bit rx_hold_req;

  always #6 clk_i = ~clk_i;

  composite_colour_decoder_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    $display("tb: mismatch on %s: expected %0d, got %0d at %0t", what, want_v, got_v, $time);
    err_count++;
  endtask

  function automatic ccd_result_t decode_rgb(input logic [CODE_W-1:0] pa, pb, pc, pd);
    longint s0, s1, s2, s3, sum, di, dq, yw, iw, qw, y16, bri;
    longint w [3];
    longint ch;
    logic [CHAN_W-1:0] sat [3];
    ccd_result_t r;
    s0 = longint'(wave_tbl[{pa, pb, 2'd0}]);
    s1 = longint'(wave_tbl[{pb, pc, 2'd1}]);
    s2 = longint'(wave_tbl[{pc, pd, 2'd2}]);
    s3 = longint'(wave_tbl[{pd, pa, 2'd3}]);
    sum = s0 + s1 + s2 + s3;
    di = s0 - s2;
    dq = s1 - s3;
    bri = longint'(gain_bri);
    yw = sum * longint'(gain_con) + (bri <<< (FB + 2));
    iw = 2 * (di * longint'(gain_re) - dq * longint'(gain_im));
    qw = 2 * (di * longint'(gain_im) + dq * longint'(gain_re));
    y16 = yw * 65536;
    w[0] = y16 + K_RI * iw + K_RQ * qw;
    w[1] = y16 - K_GI * iw - K_GQ * qw;
    w[2] = y16 - K_BI * iw + K_BQ * qw;
    r.clipped = 1'b0;
    for (int c = 0; c < 3; c++) begin
      ch = w[c] >>> (2 * FB + 10);
      if (ch < 0) begin
        sat[c] = '0;
        r.clipped = 1'b1;
      end else if (ch > 255) begin
        sat[c] = '1;
        r.clipped = 1'b1;
      end else begin
        sat[c] = ch[CHAN_W-1:0];
      end
    end
    r.red = sat[0];
    r.green = sat[1];
    r.blue = sat[2];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return SAMPLE_W'($urandom_range(4096, 0));
    if (r < 85) return SAMPLE_W'($urandom());
    case ($urandom_range(3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  function automatic pix_item_t make_load(input logic [INDEX_W-1:0] idx);
    pix_item_t it;
    it.act = ACT_LOAD;
    it.idx = idx;
    it.smp = pick_sample();
    it.pa = CODE_W'($urandom());
    it.pb = CODE_W'($urandom());
    it.pc = CODE_W'($urandom());
    it.pd = CODE_W'($urandom());
    return it;
  endfunction

  function automatic void add_row(input action_e act, input int idx, input int smp,
                                  input int pa, pb, pc, pd, input bit chk,
                                  input int r, g, b, clip);
    dir_row_t row;
    row.it.act = act;
    row.it.idx = INDEX_W'(idx);
    row.it.smp = SAMPLE_W'(smp);
    row.it.pa = CODE_W'(pa);
    row.it.pb = CODE_W'(pb);
    row.it.pc = CODE_W'(pc);
    row.it.pd = CODE_W'(pd);
    row.chk = chk;
    row.rgb.red = CHAN_W'(r);
    row.rgb.green = CHAN_W'(g);
    row.rgb.blue = CHAN_W'(b);
    row.rgb.clipped = clip[0];
    dir_rows.push_back(row);
  endfunction

  task automatic push_item(input pix_item_t it, input bit typed, input ccd_result_t typed_rgb);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.act;
    s_axis_tdata <= {6'd0, it.pd, it.pc, it.pb, it.pa, it.smp, it.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.act == ACT_LOAD) begin
      wave_tbl[it.idx] = it.smp;
      tbl_loaded[it.idx] = 1'b1;
      n_loads++;
    end else begin
      rgb_expected_q.push_back(typed ? typed_rgb : decode_rgb(it.pa, it.pb, it.pc, it.pd));
      n_decodes++;
    end
  endtask

  task automatic pace_sender(input bit bursty);
    if (bursty) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(9) == 0 ? $urandom_range(40, 10) : $urandom_range(8, 1))
          @(posedge clk_i);
        burst_left = $urandom_range(24, 1);
      end
      burst_left--;
    end
  endtask

  task automatic cfg_write(input cfg_reg_e which, input logic [REG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (which)
      CFG_CONTRAST:   gain_con = val;
      CFG_BRIGHTNESS: gain_bri = val;
      CFG_CHROMA_RE:  gain_re = val;
      CFG_CHROMA_IM:  gain_im = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [REG_W-1:0] con, bri, re, im);
    cfg_write(CFG_CONTRAST, con);
    cfg_write(CFG_BRIGHTNESS, bri);
    cfg_write(CFG_CHROMA_RE, re);
    cfg_write(CFG_CHROMA_IM, im);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic apply_near_unity();
    apply_settings(REG_W'($urandom_range(8192, 2048)), REG_W'($urandom_range(4096, 0) - 2048),
                   REG_W'($urandom_range(6144, 2048)), REG_W'($urandom_range(4096, 0) - 2048));
  endtask

  task automatic wait_idle();
    while (rgb_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_stream(input int n_items, input bit bursty);
    int sent;
    pix_item_t it;
    logic [INDEX_W-1:0] need [4];
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        pace_sender(bursty);
        push_item(make_load(INDEX_W'($urandom())), 1'b0, '0);
        sent++;
      end else begin
        it.act = ACT_DECODE;
        it.idx = INDEX_W'($urandom());
        it.smp = SAMPLE_W'($urandom());
        it.pa = CODE_W'($urandom());
        it.pb = CODE_W'($urandom());
        it.pc = CODE_W'($urandom());
        it.pd = CODE_W'($urandom());
        need[0] = {it.pa, it.pb, 2'd0};
        need[1] = {it.pb, it.pc, 2'd1};
        need[2] = {it.pc, it.pd, 2'd2};
        need[3] = {it.pd, it.pa, 2'd3};
        for (int p = 0; p < 4; p++) begin
          if (!tbl_loaded[need[p]]) begin
            pace_sender(bursty);
            push_item(make_load(need[p]), 1'b0, '0);
            sent++;
          end
        end
        pace_sender(bursty);
        push_item(it, 1'b0, '0);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Result stall pattern, with one long hold-off on request
  initial begin
    int hold_left;
    int rx_cycle;
    bit hold_done;
    m_axis_tready = 1'b0;
    hold_left = 0;
    rx_cycle = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        case ((rx_cycle / 64) % 4)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(9) < 7);
          2: m_axis_tready <= ((rx_cycle % 4) == 0);
          default: m_axis_tready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_rgb.red = m_axis_tdata[7:0];
      got_rgb.green = m_axis_tdata[15:8];
      got_rgb.blue = m_axis_tdata[23:16];
      got_rgb.clipped = m_axis_tuser;
      if (rgb_expected_q.size() == 0) begin
        report_mismatch("unexpected result item", -1, int'(m_axis_tdata));
      end else begin
        want_rgb = rgb_expected_q.pop_front();
        n_results++;
        if (got_rgb.clipped) n_clipped++;
        if (got_rgb.red !== want_rgb.red)
          report_mismatch("red", int'(want_rgb.red), int'(got_rgb.red));
        if (got_rgb.green !== want_rgb.green)
          report_mismatch("green", int'(want_rgb.green), int'(got_rgb.green));
        if (got_rgb.blue !== want_rgb.blue)
          report_mismatch("blue", int'(want_rgb.blue), int'(got_rgb.blue));
        if (got_rgb.clipped !== want_rgb.clipped)
          report_mismatch("clipped", int'(want_rgb.clipped), int'(got_rgb.clipped));
      end
    end
  end

  initial begin
    #6ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_CONTRAST;
    cfg_data_i = '0;
    rx_hold_req = 1'b0;
    burst_left = 0;
    n_loads = 0;
    n_decodes = 0;
    n_settings = 0;
    gain_con = 20'sd4096;
    gain_bri = '0;
    gain_re = 20'sd4096;
    gain_im = '0;
    for (int i = 0; i < 1024; i++) begin
      wave_tbl[i] = '0;
      tbl_loaded[i] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apply_settings(20'sd4096, 20'sd0, 20'sd4096, 20'sd0);

    add_row(ACT_LOAD, 0, 0, 15, 15, 15, 15, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 1, 0, 15, 0, 15, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 2, 0, 0, 15, 0, 15, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 3, 0, 9, 6, 3, 12, 0, 0, 0, 0, 0);
    add_row(ACT_DECODE, 1023, -32768, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(ACT_LOAD, 1020, 2048, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 1021, 2048, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 1022, 2048, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 1023, 2048, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_DECODE, 0, 32767, 15, 15, 15, 15, 1, 128, 128, 128, 0);
    add_row(ACT_LOAD, 340, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 341, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 342, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 343, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_DECODE, 682, 12345, 5, 5, 5, 5, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 0, 4096, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 1, 4096, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 2, 4096, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 3, 4096, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_DECODE, 0, 0, 0, 0, 0, 0, 1, 255, 255, 255, 1);
    add_row(ACT_LOAD, 1020, -4096, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 1021, -4096, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 1022, -4096, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_LOAD, 1023, -4096, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_DECODE, 0, 0, 15, 15, 15, 15, 1, 0, 0, 0, 1);
    foreach (dir_rows[i]) begin
      pace_sender(1'b1);
      push_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].rgb);
    end
    s_axis_tvalid <= 1'b0;
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: apply_settings(20'sh7ffff, 20'sh7ffff, 20'sh7ffff, 20'sh7ffff);
        2: apply_settings(20'sh80000, 20'sh80000, 20'sh80000, 20'sh80000);
        3: apply_settings(REG_W'($urandom()), REG_W'($urandom()),
                          REG_W'($urandom()), REG_W'($urandom()));
        5: apply_settings(20'sh7ffff, 20'sh80000, 20'sh80000, 20'sh7ffff);
        default: apply_near_unity();
      endcase
      run_stream(300, (ph != 1) && (ph != 4));
      wait_idle();
    end

    // Hold off results while items keep coming, to fill the unit
    apply_near_unity();
    rx_hold_req = 1'b1;
    run_stream(120, 1'b0);
    wait_idle();

    $display("tb: %0d loads, %0d decodes over %0d register settings", n_loads, n_decodes,
             n_settings);
    $display("tb: %0d result items checked, %0d of them clipped", n_results, n_clipped);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
